FILE: design/kwmh_pkg.sv
`timescale 1ns / 1ps

package kwmh_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_BYTES = 8;

  localparam int KEY_W   = 64;
  localparam int SRC_W   = 6;
  localparam int ACT_W   = 2;
  localparam int ERR_W   = 2;
  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CIDX_W  = IDX_W + 2;

  localparam int IN_W        = ACT_W + KEY_W + SRC_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = KEY_W + SRC_W + 1 + 1 + CNT_W + ERR_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // only the low KEY_BYTES bytes of a key take part
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POP      = 2'd1,
    ACT_POP_PUSH = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } error_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TOP_DATA,
    ST_SD_RD,
    ST_SD_CMP,
    ST_PUSH,
    ST_SU_RD,
    ST_SU_CMP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SRC_W-1:0] src;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic top_rd;
    logic top_take;
    logic sd_rd;
    logic sd_step;
    logic push_init;
    logic su_rd;
    logic su_step;
    logic su_place;
    logic err_full;
    logic err_empty;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    empty;
    logic    full;
    logic    sd_swap;
    logic    su_swap;
    logic    at_root;
  } status_t;

endpackage

FILE: design/kway_merge_min_heap.sv
`timescale 1ns / 1ps

// Channel     | Dir | Handshake                    | Content
// ------------+-----+------------------------------+-------------------------------------
// s_axis      | in  | s_axis_tvalid/s_axis_tready  | action, key, source
// m_axis      | out | m_axis_tvalid/m_axis_tready  | key, source, valid, dup, count, error
// cfg         | in  | cfg_we_i (no wait)           | dedup_enable
//
// One item in flight at a time; each heap level walked takes an address step,
// then a compare step on the registered RAM read, 6 levels at most.
// The next item is taken while a result sits unclaimed in the output register;
// it then waits in the response state until that slot frees.
// Reset (async, active low) empties the heap and clears the last emitted key.

module kway_merge_min_heap (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,  // dedup_enable

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] action, [65:2] key, [71:66] source
  input  logic [kwmh_pkg::IN_TDATA_W-1:0]   s_axis_tdata,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] out_key, [69:64] out_source, [70] out_valid, [71] duplicate,
  // [78:72] entry_count, [80:79] error, rest zero
  output logic [kwmh_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  kwmh_pkg::cmd_t    cmd;
  kwmh_pkg::status_t status;

  logic [kwmh_pkg::KEY_W-1:0] out_key;
  logic [kwmh_pkg::SRC_W-1:0] out_src;
  logic                       out_vld;
  logic                       out_dup;
  logic [kwmh_pkg::CNT_W-1:0] out_cnt;
  logic [kwmh_pkg::ERR_W-1:0] out_err;

  // sequencer: decode, top removal, sift-down and sift-up walks, response
  kwmh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // heap RAM, hole-based sift datapath, dedup tracking, output register
  kwmh_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_action_i (s_axis_tdata[kwmh_pkg::ACT_W-1:0]),
    .in_key_i    (s_axis_tdata[kwmh_pkg::ACT_W +: kwmh_pkg::KEY_W]),
    .in_src_i    (s_axis_tdata[kwmh_pkg::ACT_W + kwmh_pkg::KEY_W +: kwmh_pkg::SRC_W]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_key_o   (out_key),
    .out_src_o   (out_src),
    .out_vld_o   (out_vld),
    .out_dup_o   (out_dup),
    .out_cnt_o   (out_cnt),
    .out_err_o   (out_err)
  );

  assign m_axis_tdata = {{(kwmh_pkg::OUT_TDATA_W - kwmh_pkg::OUT_W){1'b0}},
                         out_err, out_cnt, out_dup, out_vld, out_src, out_key};

endmodule

FILE: design/kwmh_ram.sv
`timescale 1ns / 1ps

module kwmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

FILE: design/kwmh_ctrl.sv
`timescale 1ns / 1ps

module kwmh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              m_ready_i,
  output logic              m_valid_o,
  input  kwmh_pkg::status_t status_i,
  output kwmh_pkg::cmd_t    cmd_o
);

  kwmh_pkg::state_e state_q, state_d;
  logic             m_valid_q, m_valid_d;
  logic             out_free;

  assign out_free  = !m_valid_q || m_ready_i;
  assign m_valid_o = m_valid_q;
  assign s_ready_o = (state_q == kwmh_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kwmh_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = kwmh_pkg::ST_DECODE;
      end
      kwmh_pkg::ST_DECODE: begin
        unique case (status_i.act)
          kwmh_pkg::ACT_PUSH: begin
            state_d = status_i.full ? kwmh_pkg::ST_RESP : kwmh_pkg::ST_PUSH;
          end
          kwmh_pkg::ACT_POP, kwmh_pkg::ACT_POP_PUSH: begin
            state_d = status_i.empty ? kwmh_pkg::ST_RESP : kwmh_pkg::ST_TOP_DATA;
          end
          kwmh_pkg::ACT_NONE: state_d = kwmh_pkg::ST_RESP;
          default:            state_d = kwmh_pkg::ST_RESP;
        endcase
      end
      kwmh_pkg::ST_TOP_DATA: state_d = kwmh_pkg::ST_SD_RD;
      kwmh_pkg::ST_SD_RD:    state_d = kwmh_pkg::ST_SD_CMP;
      kwmh_pkg::ST_SD_CMP: begin
        priority if (status_i.sd_swap) begin
          state_d = kwmh_pkg::ST_SD_RD;
        end else if (status_i.act == kwmh_pkg::ACT_POP_PUSH) begin
          state_d = kwmh_pkg::ST_PUSH;
        end else begin
          state_d = kwmh_pkg::ST_RESP;
        end
      end
      kwmh_pkg::ST_PUSH: state_d = kwmh_pkg::ST_SU_RD;
      kwmh_pkg::ST_SU_RD: begin
        state_d = status_i.at_root ? kwmh_pkg::ST_RESP : kwmh_pkg::ST_SU_CMP;
      end
      kwmh_pkg::ST_SU_CMP: begin
        state_d = status_i.su_swap ? kwmh_pkg::ST_SU_RD : kwmh_pkg::ST_RESP;
      end
      kwmh_pkg::ST_RESP: begin
        if (out_free) state_d = kwmh_pkg::ST_IDLE;
      end
      default: state_d = kwmh_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      kwmh_pkg::ST_IDLE: cmd_o.accept = s_valid_i;
      kwmh_pkg::ST_DECODE: begin
        unique case (status_i.act)
          kwmh_pkg::ACT_PUSH: cmd_o.err_full = status_i.full;
          kwmh_pkg::ACT_POP, kwmh_pkg::ACT_POP_PUSH: begin
            cmd_o.err_empty = status_i.empty;
            cmd_o.top_rd    = !status_i.empty;
          end
          kwmh_pkg::ACT_NONE: cmd_o = '0;
          default:            cmd_o = '0;
        endcase
      end
      kwmh_pkg::ST_TOP_DATA: cmd_o.top_take  = 1'b1;
      kwmh_pkg::ST_SD_RD:    cmd_o.sd_rd     = 1'b1;
      kwmh_pkg::ST_SD_CMP:   cmd_o.sd_step   = 1'b1;
      kwmh_pkg::ST_PUSH:     cmd_o.push_init = 1'b1;
      kwmh_pkg::ST_SU_RD: begin
        cmd_o.su_place = status_i.at_root;
        cmd_o.su_rd    = !status_i.at_root;
      end
      kwmh_pkg::ST_SU_CMP: cmd_o.su_step  = 1'b1;
      kwmh_pkg::ST_RESP:   cmd_o.load_out = out_free;
      default:             cmd_o = '0;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    priority if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kwmh_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

FILE: design/kwmh_dpath.sv
`timescale 1ns / 1ps

module kwmh_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic [kwmh_pkg::ACT_W-1:0]  in_action_i,
  input  logic [kwmh_pkg::KEY_W-1:0]  in_key_i,
  input  logic [kwmh_pkg::SRC_W-1:0]  in_src_i,
  input  kwmh_pkg::cmd_t              cmd_i,
  output kwmh_pkg::status_t           status_o,
  output logic [kwmh_pkg::KEY_W-1:0]  out_key_o,
  output logic [kwmh_pkg::SRC_W-1:0]  out_src_o,
  output logic                        out_vld_o,
  output logic                        out_dup_o,
  output logic [kwmh_pkg::CNT_W-1:0]  out_cnt_o,
  output logic [kwmh_pkg::ERR_W-1:0]  out_err_o
);

  // control state
  logic [kwmh_pkg::CNT_W-1:0] fill_q, fill_d;
  logic                       last_vld_q, last_vld_d;
  logic [kwmh_pkg::KEY_W-1:0] last_q, last_d;
  logic                       dedup_q, dedup_d;

  // working registers
  kwmh_pkg::action_e          act_q, act_d;
  logic [kwmh_pkg::KEY_W-1:0] key_q, key_d;
  logic [kwmh_pkg::SRC_W-1:0] src_q, src_d;
  kwmh_pkg::entry_t           x_q, x_d;
  logic [kwmh_pkg::IDX_W-1:0] pos_q, pos_d;
  logic [kwmh_pkg::KEY_W-1:0] rkey_q, rkey_d;
  logic [kwmh_pkg::SRC_W-1:0] rsrc_q, rsrc_d;
  logic                       rvld_q, rvld_d;
  logic                       rdup_q, rdup_d;
  kwmh_pkg::error_e           rerr_q, rerr_d;

  // output register
  logic [kwmh_pkg::KEY_W-1:0] okey_q, okey_d;
  logic [kwmh_pkg::SRC_W-1:0] osrc_q, osrc_d;
  logic                       ovld_q, ovld_d;
  logic                       odup_q, odup_d;
  logic [kwmh_pkg::CNT_W-1:0] ocnt_q, ocnt_d;
  kwmh_pkg::error_e           oerr_q, oerr_d;

  // heap memory
  logic                       wr_en;
  logic [kwmh_pkg::IDX_W-1:0] wr_addr;
  kwmh_pkg::entry_t           wr_data;
  logic [kwmh_pkg::IDX_W-1:0] ra0, ra1;
  kwmh_pkg::entry_t           rd0, rd1;

  // index arithmetic
  logic [kwmh_pkg::CIDX_W-1:0] c1_idx, c2_idx, child_idx, fill_ext;
  logic                        c1_ok, c2_ok, pick_right, sd_swap, su_swap;
  kwmh_pkg::entry_t            child;
  logic [kwmh_pkg::IDX_W-1:0]  parent_idx, pos_dec;
  logic [kwmh_pkg::CNT_W-1:0]  fill_dec;

  kwmh_ram #(
    .WIDTH ($bits(kwmh_pkg::entry_t)),
    .DEPTH (kwmh_pkg::CAPACITY)
  ) u_heap_ram (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (wr_addr),
    .wdata_i  (wr_data),
    .raddr0_i (ra0),
    .raddr1_i (ra1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  assign fill_ext = kwmh_pkg::CIDX_W'(fill_q);
  assign fill_dec = fill_q - kwmh_pkg::CNT_W'(1);
  assign c1_idx   = {1'b0, pos_q, 1'b1};
  assign c2_idx   = {({1'b0, pos_q} + (kwmh_pkg::IDX_W + 1)'(1)), 1'b0};
  assign c1_ok    = c1_idx < fill_ext;
  assign c2_ok    = c2_idx < fill_ext;

  // left child wins unless the right one is strictly smaller
  assign pick_right = c2_ok && (rd0.key > rd1.key);
  assign child      = pick_right ? rd1 : rd0;
  assign child_idx  = pick_right ? c2_idx : c1_idx;
  assign sd_swap    = c1_ok && (child.key < x_q.key);

  assign pos_dec    = pos_q - kwmh_pkg::IDX_W'(1);
  assign parent_idx = pos_dec >> 1;
  assign su_swap    = rd0.key > x_q.key;

  assign status_o.act     = act_q;
  assign status_o.empty   = (fill_q == '0);
  assign status_o.full    = (fill_q == kwmh_pkg::CNT_W'(kwmh_pkg::CAPACITY));
  assign status_o.sd_swap = sd_swap;
  assign status_o.su_swap = su_swap;
  assign status_o.at_root = (pos_q == '0);

  // memory ports
  always_comb begin
    ra0 = '0;
    ra1 = '0;
    if (cmd_i.top_rd) begin
      ra1 = fill_dec[kwmh_pkg::IDX_W-1:0];
    end
    if (cmd_i.sd_rd) begin
      ra0 = c1_idx[kwmh_pkg::IDX_W-1:0];
      ra1 = c2_idx[kwmh_pkg::IDX_W-1:0];
    end
    if (cmd_i.su_rd) begin
      ra0 = parent_idx;
    end
    wr_en   = cmd_i.sd_step || cmd_i.su_step || cmd_i.su_place;
    wr_addr = pos_q;
    priority if (cmd_i.sd_step && sd_swap) begin
      wr_data = child;
    end else if (cmd_i.su_step && su_swap) begin
      wr_data = rd0;
    end else begin
      wr_data = x_q;
    end
  end

  always_comb begin
    fill_d     = fill_q;
    last_vld_d = last_vld_q;
    last_d     = last_q;
    dedup_d    = cfg_we_i ? cfg_wdata_i : dedup_q;
    act_d      = act_q;
    key_d      = key_q;
    src_d      = src_q;
    x_d        = x_q;
    pos_d      = pos_q;
    rkey_d     = rkey_q;
    rsrc_d     = rsrc_q;
    rvld_d     = rvld_q;
    rdup_d     = rdup_q;
    rerr_d     = rerr_q;
    okey_d     = okey_q;
    osrc_d     = osrc_q;
    ovld_d     = ovld_q;
    odup_d     = odup_q;
    ocnt_d     = ocnt_q;
    oerr_d     = oerr_q;

    if (cmd_i.accept) begin
      act_d  = kwmh_pkg::action_e'(in_action_i);
      key_d  = in_key_i & kwmh_pkg::KEY_MASK;
      src_d  = in_src_i;
      rkey_d = '0;
      rsrc_d = '0;
      rvld_d = 1'b0;
      rdup_d = 1'b0;
      rerr_d = kwmh_pkg::ERR_NONE;
    end
    if (cmd_i.err_full)  rerr_d = kwmh_pkg::ERR_FULL;
    if (cmd_i.err_empty) rerr_d = kwmh_pkg::ERR_EMPTY;

    // top leaves, last entry becomes the hole filler
    if (cmd_i.top_take) begin
      rkey_d = rd0.key;
      rsrc_d = rd0.src;
      x_d    = rd1;
      fill_d = fill_dec;
      pos_d  = '0;
      if (dedup_q && last_vld_q && (rd0.key == last_q)) begin
        rdup_d = 1'b1;
      end else begin
        rvld_d     = 1'b1;
        last_d     = rd0.key;
        last_vld_d = 1'b1;
      end
    end
    if (cmd_i.sd_step && sd_swap) begin
      pos_d = child_idx[kwmh_pkg::IDX_W-1:0];
    end
    if (cmd_i.push_init) begin
      pos_d     = fill_q[kwmh_pkg::IDX_W-1:0];
      x_d.key   = key_q;
      x_d.src   = src_q;
      fill_d    = fill_q + kwmh_pkg::CNT_W'(1);
    end
    if (cmd_i.su_step && su_swap) begin
      pos_d = parent_idx;
    end
    if (cmd_i.load_out) begin
      okey_d = rkey_q;
      osrc_d = rsrc_q;
      ovld_d = rvld_q;
      odup_d = rdup_q;
      ocnt_d = fill_q;
      oerr_d = rerr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      last_vld_q <= 1'b0;
      last_q     <= '0;
      dedup_q    <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      last_vld_q <= last_vld_d;
      last_q     <= last_d;
      dedup_q    <= dedup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    key_q  <= key_d;
    src_q  <= src_d;
    x_q    <= x_d;
    pos_q  <= pos_d;
    rkey_q <= rkey_d;
    rsrc_q <= rsrc_d;
    rvld_q <= rvld_d;
    rdup_q <= rdup_d;
    rerr_q <= rerr_d;
    okey_q <= okey_d;
    osrc_q <= osrc_d;
    ovld_q <= ovld_d;
    odup_q <= odup_d;
    ocnt_q <= ocnt_d;
    oerr_q <= oerr_d;
  end

  assign out_key_o = okey_q;
  assign out_src_o = osrc_q;
  assign out_vld_o = ovld_q;
  assign out_dup_o = odup_q;
  assign out_cnt_o = ocnt_q;
  assign out_err_o = oerr_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the k-way merge min-heap.
//  - sender: clocked driver at negedge, fed from heap_cmds by the stimulus block
//  - receiver: random tready stalls, results checked at posedge in arrival order
//  - heap behavior is predicted at the moment each item is accepted
module tb;
  import kwmh_pkg::*;

  // one input item as it travels on s_axis_tdata: {source, key, action}
  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [KEY_W-1:0] key;
    action_e          act;
  } heap_cmd_t;

  // one result, laid out as the low bits of m_axis_tdata
  typedef struct packed {
    error_e           err;
    logic [CNT_W-1:0] count;
    logic             dup;
    logic             emitted;
    logic [SRC_W-1:0] src;
    logic [KEY_W-1:0] key;
  } heap_resp_t;

  localparam int RESP_W = $bits(heap_resp_t);

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_wdata_i = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  kway_merge_min_heap dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predicted heap: own copy of entries, fill level and last emitted key
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] heap_key [CAPACITY];
  logic [SRC_W-1:0] heap_src [CAPACITY];
  int unsigned      heap_fill;
  logic [KEY_W-1:0] last_key;
  bit               last_key_ok;
  bit               dedup_on;

  heap_resp_t       due_results[$];   // predicted results, oldest first
  heap_cmd_t        heap_cmds[$];     // items waiting to be sent

  // run statistics
  int unsigned n_items, n_inserts, n_removals, n_dups;
  int unsigned n_full_errs, n_empty_errs, n_idle_cmds, peak_fill;
  int unsigned n_mismatch;

  task automatic swap_entries(input int unsigned a, input int unsigned b);
    logic [KEY_W-1:0] k;
    logic [SRC_W-1:0] s;
    k = heap_key[a];
    s = heap_src[a];
    heap_key[a] = heap_key[b];
    heap_src[a] = heap_src[b];
    heap_key[b] = k;
    heap_src[b] = s;
  endtask

  // append at the bottom, then sift up while the parent is strictly larger
  task automatic heap_insert(input logic [KEY_W-1:0] k, input logic [SRC_W-1:0] s);
    int unsigned c;
    int unsigned p;
    c = heap_fill;
    heap_key[c] = k;
    heap_src[c] = s;
    heap_fill++;
    n_inserts++;
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    while (c > 0) begin
      p = (c - 1) / 2;
      if (heap_key[p] <= heap_key[c]) break;
      swap_entries(p, c);
      c = p;
    end
  endtask

  // take the root, move the last entry up, sift down (left child wins ties)
  task automatic heap_remove(output logic [KEY_W-1:0] k, output logic [SRC_W-1:0] s);
    int unsigned n, p, c1, c2, c;
    n = heap_fill - 1;
    p = 0;
    k = heap_key[0];
    s = heap_src[0];
    heap_key[0] = heap_key[n];
    heap_src[0] = heap_src[n];
    heap_fill = n;
    n_removals++;
    forever begin
      c1 = 2 * p + 1;
      c2 = 2 * p + 2;
      if (c1 >= n) c1 = p;
      if (c2 >= n) c2 = p;
      c = (heap_key[c1] > heap_key[c2]) ? c2 : c1;
      if (heap_key[p] <= heap_key[c]) break;
      swap_entries(p, c);
      p = c;
    end
  endtask

  // expected result of one accepted item
  task automatic heap_step(input heap_cmd_t cmd, output heap_resp_t r);
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] top_key;
    logic [SRC_W-1:0] top_src;
    r = '0;
    k = cmd.key & KEY_MASK;
    case (cmd.act)
      ACT_PUSH: begin
        if (heap_fill >= CAPACITY) begin
          r.err = ERR_FULL;
          n_full_errs++;
        end else begin
          heap_insert(k, cmd.src);
        end
      end
      ACT_POP, ACT_POP_PUSH: begin
        if (heap_fill == 0) begin
          // nothing removed, and no push either
          r.err = ERR_EMPTY;
          n_empty_errs++;
        end else begin
          heap_remove(top_key, top_src);
          r.key = top_key;
          r.src = top_src;
          if (dedup_on && last_key_ok && top_key == last_key) begin
            r.dup = 1'b1;
            n_dups++;
          end else begin
            // emitted keys are tracked even with dedup off
            r.emitted = 1'b1;
            last_key = top_key;
            last_key_ok = 1'b1;
          end
          if (cmd.act == ACT_POP_PUSH) heap_insert(k, cmd.src);
        end
      end
      default: n_idle_cmds++;
    endcase
    r.count = CNT_W'(heap_fill);
  endtask

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, a few long, plus stall-free stretches
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: presents the next item once the current one is taken
  // ---------------------------------------------------------------------------
  bit          in_taken;
  int unsigned send_gap, send_calm;
  heap_cmd_t   next_cmd;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (heap_cmds.size() > 0) begin
        next_cmd = heap_cmds.pop_front();
        s_axis_tdata <= IN_TDATA_W'(next_cmd);
        s_axis_tvalid <= 1'b1;
        send_gap = idle_len(send_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a fresh stall length after every result it takes
  // ---------------------------------------------------------------------------
  bit          out_taken;
  int unsigned recv_stall, recv_calm;

  always @(negedge clk_i) begin
    if (out_taken) begin
      out_taken = 1'b0;
      recv_stall = idle_len(recv_calm);
    end
    if (!rst_ni || recv_stall > 0) begin
      if (recv_stall > 0) recv_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results in order, predict each accepted item
  // ---------------------------------------------------------------------------
  heap_resp_t got, want, pred;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_taken = 1'b1;
        got = heap_resp_t'(m_axis_tdata[RESP_W-1:0]);
        if (due_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: result with nothing pending: key=%h src=%0d cnt=%0d err=%0d",
                     $realtime, got.key, got.src, got.count, got.err);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display({"%0t: mismatch\n  want key=%h src=%0d emit=%b dup=%b cnt=%0d err=%0d",
                        "\n  got  key=%h src=%0d emit=%b dup=%b cnt=%0d err=%0d"},
                       $realtime, want.key, want.src, want.emitted, want.dup, want.count,
                       want.err, got.key, got.src, got.emitted, got.dup, got.count, got.err);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        heap_step(heap_cmd_t'(s_axis_tdata), pred);
        due_results.push_back(pred);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int unsigned gen_fill;   // fill level as the item generator sees it

  task automatic add_cmd(input action_e a, input logic [KEY_W-1:0] k,
                         input logic [SRC_W-1:0] s);
    heap_cmd_t c;
    c.act = a;
    c.key = k;
    c.src = s;
    heap_cmds.push_back(c);
    n_items++;
    case (a)
      ACT_PUSH: if (gen_fill < CAPACITY) gen_fill++;
      ACT_POP:  if (gen_fill > 0) gen_fill--;
      default: ;
    endcase
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    int unsigned r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    k = {$urandom, $urandom};
    if (r < 30) begin
      k = KEY_W'($urandom_range(0, 15));
    end else if (r < 45) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = '1;
        2: k = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
        default: k = ~(KEY_W'(1) << $urandom_range(0, KEY_W - 1));
      endcase
    end else if (r < 60) begin
      // short string: leading bytes set, tail zero padded
      k = k & ~({KEY_W{1'b1}} >> (8 * $urandom_range(1, 7)));
    end
    return k;
  endfunction

  // merge-like traffic: load run heads, then replace the top with the next key
  task automatic gen_merge(input int unsigned budget);
    int unsigned done;
    int unsigned runs;
    int unsigned r;
    logic [KEY_W-1:0] head;
    done = 0;
    head = '0;
    while (done < budget) begin
      if (gen_fill == 0) begin
        runs = ($urandom_range(0, 3) == 0) ? CAPACITY : $urandom_range(1, 16);
        head = KEY_W'($urandom) << $urandom_range(0, 32);
        for (int i = 0; i < runs; i++) begin
          add_cmd(ACT_PUSH, head + $urandom_range(0, 3), SRC_W'(i));
          done++;
        end
      end else begin
        r = $urandom_range(0, 99);
        head = head + $urandom_range(0, 2);   // small steps give equal keys
        if (r < 75) add_cmd(ACT_POP_PUSH, head, SRC_W'($urandom));
        else if (r < 93) add_cmd(ACT_POP, rand_key(), SRC_W'($urandom));
        else add_cmd(action_e'($urandom_range(0, 3)), rand_key(), SRC_W'($urandom));
        done++;
      end
    end
  endtask

  // run up to full, push past it, then drain past empty
  task automatic gen_fill_drain();
    while (gen_fill < CAPACITY) begin
      if ($urandom_range(0, 6) == 0) add_cmd(ACT_POP_PUSH, rand_key(), SRC_W'($urandom));
      else add_cmd(ACT_PUSH, rand_key(), SRC_W'($urandom));
    end
    repeat (3) add_cmd(ACT_PUSH, rand_key(), SRC_W'($urandom));
    repeat (2) add_cmd(ACT_POP_PUSH, rand_key(), SRC_W'($urandom));
    while (gen_fill > 0) add_cmd(ACT_POP, rand_key(), SRC_W'($urandom));
    add_cmd(ACT_POP, rand_key(), SRC_W'($urandom));
    add_cmd(ACT_POP_PUSH, rand_key(), SRC_W'($urandom));
  endtask

  task automatic gen_noise(input int unsigned budget);
    repeat (budget) add_cmd(action_e'($urandom_range(0, 3)), rand_key(), SRC_W'($urandom));
  endtask

  // wait until nothing is queued, in flight or outstanding, then let it settle
  task automatic settle();
    do begin
      @(posedge clk_i);
      #1;
    end while (heap_cmds.size() != 0 || (s_axis_tvalid && !in_taken) ||
               due_results.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_dedup(input bit v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    dedup_on = v;
  endtask

  initial begin
    heap_fill = 0;
    last_key = '0;
    last_key_ok = 1'b0;
    dedup_on = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-heap pops, unused code, key extremes, ties, duplicates
    set_dedup(1'b1);
    add_cmd(ACT_POP,      '1, '1);
    add_cmd(ACT_POP_PUSH, 64'h1, 6'd9);         // empty: the push must not happen
    add_cmd(ACT_NONE,     '1, '1);
    add_cmd(ACT_PUSH,     '0, '0);
    add_cmd(ACT_PUSH,     '1, '1);
    add_cmd(ACT_PUSH,     64'h8000_0000_0000_0000, 6'd21);
    add_cmd(ACT_PUSH,     64'd5, 6'd1);
    add_cmd(ACT_PUSH,     64'd5, 6'd2);
    add_cmd(ACT_PUSH,     64'd5, 6'd3);
    add_cmd(ACT_POP,      '0, '0);              // key 0, nothing emitted before
    add_cmd(ACT_POP,      '0, '0);
    add_cmd(ACT_POP,      '0, '0);              // equal key again: duplicate
    add_cmd(ACT_POP_PUSH, 64'd5, 6'd4);
    add_cmd(ACT_POP_PUSH, 64'h0123_4567_89AB_CDEF, 6'd42);
    add_cmd(ACT_NONE,     '0, '0);
    repeat (4) add_cmd(ACT_POP, '0, '0);
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      set_dedup(ph[0]);
      case (ph % 3)
        0: gen_merge(150);
        1: gen_fill_drain();
        default: gen_noise(150);
      endcase
      settle();
    end

    $display("Covered %0d items: %0d inserts, %0d removals, %0d duplicates, peak fill %0d.",
             n_items, n_inserts, n_removals, n_dups, peak_fill);
    $display("Error paths: %0d full pushes, %0d empty pops, %0d unused codes; %0d mismatches.",
             n_full_errs, n_empty_errs, n_idle_cmds, n_mismatch);
    if (n_mismatch == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, well above the slowest legal run
  initial begin
    #6_000_000;
    $display("timeout with %0d results outstanding", due_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
design/kwmh_pkg.sv
design/kwmh_ram.sv
design/kwmh_ctrl.sv
design/kwmh_dpath.sv
design/kway_merge_min_heap.sv
verif/tb.sv
